// ----- design/pplu_pkg.sv -----
// ----------------------------------------------------------------------------
// Prey-predator lattice update package
// Opcodes, register indexes, reset values and the pair transition table.
// ----------------------------------------------------------------------------
package pplu_pkg;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd3;

    // Reset values of the probabilities as 16-bit fractions of one.
    localparam int unsigned ALPHA_RST16 = 14418;
    localparam int unsigned BETA_RST16  = 6554;
    localparam int unsigned GAMMA_RST16 = 58982;
    localparam int unsigned SIZE_RST    = 1000;

    typedef struct packed {
        logic prey;
        logic pred;
    } t_site;

    typedef struct packed {
        logic r1_half;
        logic r1_alpha;
        logic r1_beta;
        logic r2_alpha;
        logic r2_beta;
        logic r2_gamma;
    } t_cmp;

    // Pair code is prey_i, prey_j, pred_i, pred_j from the top bit down.
    function automatic logic [3:0] next_code(input logic [3:0] k, input t_cmp c);
        logic [3:0] n;
        n = k;
        case (k)
            4'd1, 4'd4: n = c.r1_alpha ? 4'd8 : k;
            4'd2:  n = c.r1_alpha ? 4'd1 : k;
            4'd5:  n = c.r1_alpha ? 4'd10 : k;
            4'd13: n = c.r1_alpha ? 4'd14 : k;
            4'd3:  n = c.r1_beta ? 4'd0 : k;
            4'd7:  n = c.r1_beta ? 4'd8 : k;
            4'd15: n = c.r1_beta ? 4'd12 : k;
            4'd8:  n = c.r1_half ? (c.r2_alpha ? 4'd12 : k) : 4'd4;
            4'd9:  n = c.r1_half ? (c.r2_alpha ? 4'd14 : k) : 4'd6;
            4'd10: n = c.r1_half ? (c.r2_alpha ? 4'd13 : k) : 4'd5;
            4'd14: n = c.r1_half ? (c.r2_gamma ? 4'd11 : k) : 4'd13;
            4'd6:  n = c.r1_half ? (c.r2_gamma ? 4'd3 : k) : 4'd9;
            4'd11: n = c.r1_half ? (c.r2_alpha ? 4'd15 : k)
                                 : (c.r2_beta ? 4'd4 : k);
            default: n = k;
        endcase
        return n;
    endfunction

endpackage

// ----- design/pplu_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module pplu_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 512
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/pplu_cfg.sv -----
// ----------------------------------------------------------------------------
// Prey-predator lattice configuration registers
// Holds the three probabilities and the ring size, and derives the ring size
// in use, held within two and the lattice depth.
// ----------------------------------------------------------------------------
module pplu_cfg #(
    parameter int unsigned MAX_SITES = 1024,
    parameter int unsigned PROB_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pplu_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((PROB_BITS > $clog2(MAX_SITES + 1)) ? PROB_BITS
                   : $clog2(MAX_SITES + 1))-1:0]  i_cfg_data,
    output logic [PROB_BITS-1:0]                   o_alpha,
    output logic [PROB_BITS-1:0]                   o_beta,
    output logic [PROB_BITS-1:0]                   o_gamma,
    output logic [$clog2(MAX_SITES + 1)-1:0]       o_eff_size
);

    localparam int unsigned CW    = $clog2(MAX_SITES + 1);
    localparam int unsigned SH_UP = (PROB_BITS >= 16) ? PROB_BITS - 16 : 0;
    localparam int unsigned SH_DN = (PROB_BITS < 16) ? 16 - PROB_BITS : 0;

    localparam logic [PROB_BITS-1:0] ALPHA_RST =
        PROB_BITS'((64'(pplu_pkg::ALPHA_RST16) << SH_UP) >> SH_DN);
    localparam logic [PROB_BITS-1:0] BETA_RST =
        PROB_BITS'((64'(pplu_pkg::BETA_RST16) << SH_UP) >> SH_DN);
    localparam logic [PROB_BITS-1:0] GAMMA_RST =
        PROB_BITS'((64'(pplu_pkg::GAMMA_RST16) << SH_UP) >> SH_DN);
    localparam logic [CW-1:0] SIZE_RST =
        CW'((MAX_SITES < pplu_pkg::SIZE_RST) ? MAX_SITES : pplu_pkg::SIZE_RST);
    localparam logic [CW-1:0] SIZE_MIN = CW'(2);
    localparam logic [CW-1:0] SIZE_MAX = CW'(MAX_SITES);

    logic [PROB_BITS-1:0] r_alpha;
    logic [PROB_BITS-1:0] r_beta;
    logic [PROB_BITS-1:0] r_gamma;
    logic [CW-1:0]        r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_beta  <= BETA_RST;
            r_gamma <= GAMMA_RST;
            r_size  <= SIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pplu_pkg::REG_ALPHA: r_alpha <= i_cfg_data[PROB_BITS-1:0];
                pplu_pkg::REG_BETA:  r_beta  <= i_cfg_data[PROB_BITS-1:0];
                pplu_pkg::REG_GAMMA: r_gamma <= i_cfg_data[PROB_BITS-1:0];
                pplu_pkg::REG_SIZE:  r_size  <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_size < SIZE_MIN) begin
            o_eff_size = SIZE_MIN;
        end else if (r_size > SIZE_MAX) begin
            o_eff_size = SIZE_MAX;
        end else begin
            o_eff_size = r_size;
        end
    end

    assign o_alpha = r_alpha;
    assign o_beta  = r_beta;
    assign o_gamma = r_gamma;

endmodule

// ----- design/prey_predator_lattice_update_top.sv -----
// ----------------------------------------------------------------------------
// Prey-predator lattice update
// Latency: the result strobe rises at the first clock edge after the edge
// that accepts the item, and the result is taken at the edge after that.
// Throughput: one item per cycle, set by the read-modify-write of a site pair
// through the even and odd site RAM banks with one cycle of write forwarding.
// Reset: a clearing pass of ceil(MAX_SITES/2) cycles zeroes both banks while
// busy is high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module prey_predator_lattice_update_top #(
    parameter int unsigned MAX_SITES = 1024,
    parameter int unsigned PROB_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pplu_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((PROB_BITS > $clog2(MAX_SITES + 1)) ? PROB_BITS
                   : $clog2(MAX_SITES + 1))-1:0]  i_cfg_data,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic                                   i_opcode,
    input  logic [$clog2(MAX_SITES)-1:0]           i_site,
    input  logic [PROB_BITS-1:0]                   i_rand_first,
    input  logic [PROB_BITS-1:0]                   i_rand_second,
    input  logic                                   i_prey_in,
    input  logic                                   i_predator_in,
    output logic                                   o_done,
    output logic [$clog2(MAX_SITES + 1)-1:0]       o_prey_total,
    output logic [$clog2(MAX_SITES + 1)-1:0]       o_predator_total,
    output logic                                   o_pair_changed,
    output logic                                   o_bad_site
);

    localparam int unsigned CW    = $clog2(MAX_SITES + 1);
    localparam int unsigned SW    = $clog2(MAX_SITES);
    localparam int unsigned DEPTH = (MAX_SITES + 1) / 2;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PROB_BITS-1:0] HALF = {1'b1, {(PROB_BITS - 1){1'b0}}};
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    logic [PROB_BITS-1:0] w_alpha;
    logic [PROB_BITS-1:0] w_beta;
    logic [PROB_BITS-1:0] w_gamma;
    logic [CW-1:0]        w_eff_size;

    pplu_cfg #(
        .MAX_SITES (MAX_SITES),
        .PROB_BITS (PROB_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_alpha    (w_alpha),
        .o_beta     (w_beta),
        .o_gamma    (w_gamma),
        .o_eff_size (w_eff_size)
    );

    // Clearing pass.
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Input stage.
    logic                 w_accept;
    logic [CW-1:0]        w_ip1;
    logic [SW-1:0]        w_j;
    logic                 w_bad;
    logic [AW-1:0]        w_ea;
    logic [AW-1:0]        w_oa;

    logic                 r_v;
    logic                 r_op;
    logic                 r_bad;
    logic [SW-1:0]        r_i;
    logic [SW-1:0]        r_j;
    logic [AW-1:0]        r_ea;
    logic [AW-1:0]        r_oa;
    logic [PROB_BITS-1:0] r_r1;
    logic [PROB_BITS-1:0] r_r2;
    pplu_pkg::t_site      r_wr_bits;

    // Lattice storage and forwarding records.
    pplu_pkg::t_site      r_site0;
    pplu_pkg::t_site      w_rd_e;
    pplu_pkg::t_site      w_rd_o;
    logic                 r_fw_e_v;
    logic [AW-1:0]        r_fw_e_addr;
    pplu_pkg::t_site      r_fw_e_data;
    logic                 r_fw_o_v;
    logic [AW-1:0]        r_fw_o_addr;
    pplu_pkg::t_site      r_fw_o_data;

    logic [CW-1:0]        r_prey_cnt;
    logic [CW-1:0]        r_pred_cnt;
    logic                 r_done;
    logic                 r_changed;
    logic                 r_bad_out;

    // Update stage.
    pplu_pkg::t_site      w_cur_e;
    pplu_pkg::t_site      w_cur_o;
    pplu_pkg::t_site      w_old_i;
    pplu_pkg::t_site      w_old_j;
    pplu_pkg::t_site      w_new_i;
    pplu_pkg::t_site      w_new_j;
    pplu_pkg::t_cmp       w_cmp;
    logic [3:0]           w_code;
    logic [3:0]           w_next;
    logic                 w_act;
    logic                 w_upd;
    logic                 w_i_zero;
    logic                 w_j_zero;
    logic                 w_item_we_e;
    logic                 w_item_we_o;
    pplu_pkg::t_site      w_item_wd_e;
    pplu_pkg::t_site      w_item_wd_o;
    logic                 w_ram_we_e;
    logic                 w_ram_we_o;
    logic [AW-1:0]        w_ram_wa_e;
    logic [AW-1:0]        w_ram_wa_o;
    pplu_pkg::t_site      w_ram_wd_e;
    pplu_pkg::t_site      w_ram_wd_o;
    logic [1:0]           w_prey_up;
    logic [1:0]           w_prey_dn;
    logic [1:0]           w_pred_up;
    logic [1:0]           w_pred_dn;
    logic                 w_changed;

    assign o_busy   = r_clearing;
    assign w_accept = i_start && !r_clearing;

    always_comb begin
        w_ip1 = CW'(i_site) + CW'(1);
        w_j   = (w_ip1 == w_eff_size) ? SW'(0) : SW'(w_ip1);
        w_bad = CW'(i_site) >= w_eff_size;
        w_ea  = i_site[0] ? AW'(w_j >> 1) : AW'(i_site >> 1);
        w_oa  = i_site[0] ? AW'(i_site >> 1) : AW'(w_j >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= i_opcode;
        r_bad     <= w_bad;
        r_i       <= i_site;
        r_j       <= w_j;
        r_ea      <= w_ea;
        r_oa      <= w_oa;
        r_r1      <= i_rand_first;
        r_r2      <= i_rand_second;
        r_wr_bits <= '{prey: i_prey_in, pred: i_predator_in};
    end

    pplu_ram #(
        .WIDTH ($bits(pplu_pkg::t_site)),
        .DEPTH (DEPTH)
    ) u_ram_even (
        .i_clk   (i_clk),
        .i_we    (w_ram_we_e),
        .i_waddr (w_ram_wa_e),
        .i_wdata (w_ram_wd_e),
        .i_raddr (w_ea),
        .o_rdata (w_rd_e)
    );

    pplu_ram #(
        .WIDTH ($bits(pplu_pkg::t_site)),
        .DEPTH (DEPTH)
    ) u_ram_odd (
        .i_clk   (i_clk),
        .i_we    (w_ram_we_o),
        .i_waddr (w_ram_wa_o),
        .i_wdata (w_ram_wd_o),
        .i_raddr (w_oa),
        .o_rdata (w_rd_o)
    );

    always_comb begin
        w_cur_e = (r_fw_e_v && (r_fw_e_addr == r_ea)) ? r_fw_e_data : w_rd_e;
        w_cur_o = (r_fw_o_v && (r_fw_o_addr == r_oa)) ? r_fw_o_data : w_rd_o;

        w_i_zero = (r_i == SW'(0));
        w_j_zero = (r_j == SW'(0));
        w_old_i  = w_i_zero ? r_site0 : (r_i[0] ? w_cur_o : w_cur_e);
        w_old_j  = w_j_zero ? r_site0 : (r_j[0] ? w_cur_o : w_cur_e);

        w_cmp.r1_half  = r_r1 < HALF;
        w_cmp.r1_alpha = r_r1 < w_alpha;
        w_cmp.r1_beta  = r_r1 < w_beta;
        w_cmp.r2_alpha = r_r2 < w_alpha;
        w_cmp.r2_beta  = r_r2 < w_beta;
        w_cmp.r2_gamma = r_r2 < w_gamma;

        w_code = {w_old_i.prey, w_old_j.prey, w_old_i.pred, w_old_j.pred};
        w_next = pplu_pkg::next_code(w_code, w_cmp);

        w_act = r_v && !r_bad;
        w_upd = (r_op == pplu_pkg::OP_UPDATE);

        if (w_upd) begin
            w_new_i = '{prey: w_next[3], pred: w_next[1]};
            w_new_j = '{prey: w_next[2], pred: w_next[0]};
        end else begin
            w_new_i = r_wr_bits;
            w_new_j = w_old_j;
        end

        w_item_we_e = 1'b0;
        w_item_we_o = 1'b0;
        w_item_wd_e = w_new_i;
        w_item_wd_o = w_new_i;
        if (w_act) begin
            if (!w_i_zero) begin
                if (r_i[0]) begin
                    w_item_we_o = 1'b1;
                    w_item_wd_o = w_new_i;
                end else begin
                    w_item_we_e = 1'b1;
                    w_item_wd_e = w_new_i;
                end
            end
            if (w_upd && !w_j_zero) begin
                if (r_j[0]) begin
                    w_item_we_o = 1'b1;
                    w_item_wd_o = w_new_j;
                end else begin
                    w_item_we_e = 1'b1;
                    w_item_wd_e = w_new_j;
                end
            end
        end

        if (r_clearing) begin
            w_ram_we_e = 1'b1;
            w_ram_we_o = 1'b1;
            w_ram_wa_e = r_clr_addr;
            w_ram_wa_o = r_clr_addr;
            w_ram_wd_e = '0;
            w_ram_wd_o = '0;
        end else begin
            w_ram_we_e = w_item_we_e;
            w_ram_we_o = w_item_we_o;
            w_ram_wa_e = r_ea;
            w_ram_wa_o = r_oa;
            w_ram_wd_e = w_item_wd_e;
            w_ram_wd_o = w_item_wd_o;
        end

        w_prey_up = {1'b0, w_new_i.prey & ~w_old_i.prey}
                  + {1'b0, w_upd & w_new_j.prey & ~w_old_j.prey};
        w_prey_dn = {1'b0, ~w_new_i.prey & w_old_i.prey}
                  + {1'b0, w_upd & ~w_new_j.prey & w_old_j.prey};
        w_pred_up = {1'b0, w_new_i.pred & ~w_old_i.pred}
                  + {1'b0, w_upd & w_new_j.pred & ~w_old_j.pred};
        w_pred_dn = {1'b0, ~w_new_i.pred & w_old_i.pred}
                  + {1'b0, w_upd & ~w_new_j.pred & w_old_j.pred};

        w_changed = (w_new_i != w_old_i) || (w_upd && (w_new_j != w_old_j));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site0    <= '0;
            r_prey_cnt <= '0;
            r_pred_cnt <= '0;
            r_fw_e_v   <= 1'b0;
            r_fw_o_v   <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_fw_e_v <= w_item_we_e;
            r_fw_o_v <= w_item_we_o;
            r_done   <= r_v;
            if (w_act) begin
                if (w_i_zero) begin
                    r_site0 <= w_new_i;
                end else if (w_upd && w_j_zero) begin
                    r_site0 <= w_new_j;
                end
                r_prey_cnt <= r_prey_cnt + CW'(w_prey_up) - CW'(w_prey_dn);
                r_pred_cnt <= r_pred_cnt + CW'(w_pred_up) - CW'(w_pred_dn);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_e_addr <= r_ea;
        r_fw_e_data <= w_item_wd_e;
        r_fw_o_addr <= r_oa;
        r_fw_o_data <= w_item_wd_o;
        r_changed   <= w_act && w_changed;
        r_bad_out   <= r_bad;
    end

    assign o_done           = r_done;
    assign o_prey_total     = r_prey_cnt;
    assign o_predator_total = r_pred_cnt;
    assign o_pair_changed   = r_changed;
    assign o_bad_site       = r_bad_out;

endmodule

// ----- test/tb_prey_predator_lattice_update_top.sv -----
// ----------------------------------------------------------------------------
// Prey-predator lattice update testbench
// Drives update and write commands into the ring lattice block and checks
// each result transaction against a cycle-free model of the lattice.
// The model keeps its own prey and predator bits and running counts.
// A short directed sequence covers the wrap at the ring end, bad sites,
// unchanged writes and two-draw transitions. Random phases then follow:
// probabilities at their extremes, ring sizes that saturate, a shrunk ring
// keeping old sites, and varying sender gaps and drain pauses.
// ----------------------------------------------------------------------------
module tb_prey_predator_lattice_update_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSITES = 1024;
    localparam int SITE_W = 10;
    localparam int CNT_W = 11;
    localparam int FRAC_W = 16;
    localparam logic [FRAC_W-1:0] FRAC_HALF = 16'h8000;

    typedef struct {
        logic              opcode;
        logic [SITE_W-1:0] site;
        logic [FRAC_W-1:0] r1;
        logic [FRAC_W-1:0] r2;
        logic              prey_in;
        logic              pred_in;
        bit                drain_after;
    } t_lat_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] prey_total;
        logic [CNT_W-1:0] pred_total;
        logic             changed;
        logic             bad;
    } t_lat_counts;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [pplu_pkg::CFG_IDX_W-1:0] i_cfg_idx = pplu_pkg::REG_ALPHA;
    logic [FRAC_W-1:0]              i_cfg_data = '0;
    logic                           i_start = 1'b0;
    logic                           i_opcode = pplu_pkg::OP_UPDATE;
    logic [SITE_W-1:0]              i_site = '0;
    logic [FRAC_W-1:0]              i_rand_first = '0;
    logic [FRAC_W-1:0]              i_rand_second = '0;
    logic                           i_prey_in = 1'b0;
    logic                           i_predator_in = 1'b0;
    logic                           o_busy;
    logic                           o_done;
    logic [CNT_W-1:0]               o_prey_total;
    logic [CNT_W-1:0]               o_predator_total;
    logic                           o_pair_changed;
    logic                           o_bad_site;

    prey_predator_lattice_update_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_site          (i_site),
        .i_rand_first    (i_rand_first),
        .i_rand_second   (i_rand_second),
        .i_prey_in       (i_prey_in),
        .i_predator_in   (i_predator_in),
        .o_done          (o_done),
        .o_prey_total    (o_prey_total),
        .o_predator_total(o_predator_total),
        .o_pair_changed  (o_pair_changed),
        .o_bad_site      (o_bad_site)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Lattice model state and configuration.
    bit                prey_m[NSITES];
    bit                pred_m[NSITES];
    int                prey_cnt = 0;
    int                pred_cnt = 0;
    logic [FRAC_W-1:0] alpha_m = 16'(pplu_pkg::ALPHA_RST16);
    logic [FRAC_W-1:0] beta_m = 16'(pplu_pkg::BETA_RST16);
    logic [FRAC_W-1:0] gamma_m = 16'(pplu_pkg::GAMMA_RST16);
    logic [CNT_W-1:0]  size_m = 11'(pplu_pkg::SIZE_RST);

    t_lat_cmd    cmd_q[$];
    t_lat_counts count_q[$];
    t_lat_cmd    drv_cmd;
    t_lat_counts want;
    t_lat_counts got;
    int          in_flight = 0;
    bit          drain_hold = 1'b0;
    int          idle_pct = 0;
    int          errors = 0;

    function automatic int ring_sites();
        int s;
        s = int'(size_m);
        if (s < 2) s = 2;
        if (s > NSITES) s = NSITES;
        return s;
    endfunction

    function automatic bit store_site(int idx, bit prey, bit pred);
        bit ch;
        ch = 1'b0;
        if (prey_m[idx] != prey) begin
            prey_cnt += prey ? 1 : -1;
            prey_m[idx] = prey;
            ch = 1'b1;
        end
        if (pred_m[idx] != pred) begin
            pred_cnt += pred ? 1 : -1;
            pred_m[idx] = pred;
            ch = 1'b1;
        end
        return ch;
    endfunction

    // Pair code bits from the top: prey_i, prey_j, pred_i, pred_j.
    function automatic logic [3:0] pair_next(logic [3:0] k, logic [FRAC_W-1:0] r1,
                                             logic [FRAC_W-1:0] r2);
        bit lo, a1, b1, a2, b2, g2;
        logic [3:0] n;
        lo = r1 < FRAC_HALF;
        a1 = r1 < alpha_m;
        b1 = r1 < beta_m;
        a2 = r2 < alpha_m;
        b2 = r2 < beta_m;
        g2 = r2 < gamma_m;
        n = k;
        case (k)
            4'd1, 4'd4: if (a1) n = 4'b1000;
            4'd2: if (a1) n = 4'b0001;
            4'd5: if (a1) n = 4'b1010;
            4'd13: if (a1) n = 4'b1110;
            4'd3: if (b1) n = 4'b0000;
            4'd7: if (b1) n = 4'b1000;
            4'd15: if (b1) n = 4'b1100;
            4'd8: n = !lo ? 4'b0100 : (a2 ? 4'b1100 : k);
            4'd9: n = !lo ? 4'b0110 : (a2 ? 4'b1110 : k);
            4'd10: n = !lo ? 4'b0101 : (a2 ? 4'b1101 : k);
            4'd14: n = !lo ? 4'b1101 : (g2 ? 4'b1011 : k);
            4'd6: n = !lo ? 4'b1001 : (g2 ? 4'b0011 : k);
            4'd11: n = lo ? (a2 ? 4'b1111 : k) : (b2 ? 4'b0100 : k);
            default: ;
        endcase
        return n;
    endfunction

    function automatic t_lat_counts lattice_step(t_lat_cmd c);
        int sz, i, j;
        bit ch;
        logic [3:0] k, n;
        t_lat_counts r;
        sz = ring_sites();
        ch = 1'b0;
        r.bad = 1'b0;
        if (int'(c.site) >= sz) begin
            r.bad = 1'b1;
        end else if (c.opcode == pplu_pkg::OP_WRITE) begin
            ch = store_site(int'(c.site), c.prey_in, c.pred_in);
        end else begin
            i = int'(c.site);
            j = (i + 1 == sz) ? 0 : i + 1;
            k = {prey_m[i], prey_m[j], pred_m[i], pred_m[j]};
            n = pair_next(k, c.r1, c.r2);
            ch = store_site(i, n[3], n[1]);
            ch |= store_site(j, n[2], n[0]);
        end
        r.changed = ch;
        r.prey_total = CNT_W'(prey_cnt);
        r.pred_total = CNT_W'(pred_cnt);
        return r;
    endfunction

    // Command driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (o_done === 1'b1) in_flight--;
            if (i_start && o_busy === 1'b0) begin
                count_q.push_back(lattice_step(drv_cmd));
                in_flight++;
                if (drv_cmd.drain_after) drain_hold = 1'b1;
            end
            if (drain_hold && in_flight <= 0) drain_hold = 1'b0;
            if (!(i_start && o_busy !== 1'b0)) begin
                if (cmd_q.size() != 0 && !drain_hold && $urandom_range(0, 99) >= idle_pct) begin
                    drv_cmd = cmd_q.pop_front();
                    i_start <= 1'b1;
                    i_opcode <= drv_cmd.opcode;
                    i_site <= drv_cmd.site;
                    i_rand_first <= drv_cmd.r1;
                    i_rand_second <= drv_cmd.r2;
                    i_prey_in <= drv_cmd.prey_in;
                    i_predator_in <= drv_cmd.pred_in;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            got = {o_prey_total, o_predator_total, o_pair_changed, o_bad_site};
            if (count_q.size() == 0) begin
                $display("%0t: result transaction with none expected: prey %0d pred %0d",
                         $time, got.prey_total, got.pred_total);
                errors++;
            end else begin
                want = count_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected prey %0d pred %0d chg %0b bad %0b",
                             $time, want.prey_total, want.pred_total, want.changed,
                             want.bad);
                    $display("%0t:          actual   prey %0d pred %0d chg %0b bad %0b",
                             $time, got.prey_total, got.pred_total, got.changed, got.bad);
                    errors++;
                end
            end
        end
    end

    task automatic add_cmd(logic op, int site, logic [FRAC_W-1:0] r1,
                           logic [FRAC_W-1:0] r2, bit prey, bit pred, bit drain);
        t_lat_cmd c;
        c.opcode = op;
        c.site = SITE_W'(site);
        c.r1 = r1;
        c.r2 = r2;
        c.prey_in = prey;
        c.pred_in = pred;
        c.drain_after = drain;
        cmd_q.push_back(c);
    endtask

    function automatic logic [FRAC_W-1:0] rand_frac();
        int th, v;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: begin
                case ($urandom_range(0, 3))
                    0: th = int'(alpha_m);
                    1: th = int'(beta_m);
                    2: th = int'(gamma_m);
                    default: th = int'(FRAC_HALF);
                endcase
                v = th - 1 + int'($urandom_range(0, 2));
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return FRAC_W'(v);
            end
            default: return FRAC_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_random(int n);
        int sz, site;
        sz = ring_sites();
        repeat (n) begin
            if (sz < NSITES && $urandom_range(0, 99) < 6)
                site = $urandom_range(sz, NSITES - 1);
            else if (sz > 32 && $urandom_range(0, 1) == 1)
                site = sz - 1 - $urandom_range(0, 7);
            else
                site = $urandom_range(0, sz - 1);
            add_cmd(($urandom_range(0, 99) < 35) ? pplu_pkg::OP_WRITE : pplu_pkg::OP_UPDATE,
                    site, rand_frac(), rand_frac(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), $urandom_range(0, 149) == 0);
        end
    endtask

    task automatic cfg_write(logic [pplu_pkg::CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            pplu_pkg::REG_ALPHA: alpha_m = val;
            pplu_pkg::REG_BETA: beta_m = val;
            pplu_pkg::REG_GAMMA: gamma_m = val;
            pplu_pkg::REG_SIZE: size_m = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || i_start || in_flight > 0) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [FRAC_W-1:0] a, logic [FRAC_W-1:0] b,
                             logic [FRAC_W-1:0] g, logic [FRAC_W-1:0] sz, int pct, int n);
        cfg_write(pplu_pkg::REG_ALPHA, a);
        cfg_write(pplu_pkg::REG_BETA, b);
        cfg_write(pplu_pkg::REG_GAMMA, g);
        cfg_write(pplu_pkg::REG_SIZE, sz);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        idle_pct = pct;
        queue_random(n);
        wait_drained();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
        idle_pct = 8;

        // Reset configuration: ring of 1000 sites, so site 999 wraps to 0.
        add_cmd(pplu_pkg::OP_UPDATE, 0, 16'h0000, 16'h0000, 1, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 999, 16'hFFFF, 16'hFFFF, 1, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 0, 16'h0000, 16'h0000, 0, 1, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 999, 16'h0000, 16'h0000, 1, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 999, 16'h0000, 16'hFFFF, 0, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 1000, 16'h0000, 16'h0000, 1, 1, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 1023, 16'hFFFF, 16'hFFFF, 1, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 999, 16'h1234, 16'h4321, 1, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 999, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        add_cmd(pplu_pkg::OP_WRITE, 0, 16'h0000, 16'h0000, 0, 0, 1);
        add_cmd(pplu_pkg::OP_UPDATE, 999, 16'hFFFF, 16'h0000, 0, 0, 0);
        add_cmd(pplu_pkg::OP_WRITE, 500, 16'h0000, 16'h0000, 0, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 501, 16'h0000, 16'h0000, 1, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 500, 16'h0000, 16'hFFFF, 0, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 500, 16'h0000, 16'h0000, 0, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 500, 16'h0000, 16'h0000, 1, 1, 0);
        add_cmd(pplu_pkg::OP_WRITE, 998, 16'h0000, 16'h0000, 1, 1, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 998, FRAC_HALF, 16'h0000, 0, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 998, 16'h0000, 16'h0000, 0, 0, 0);
        add_cmd(pplu_pkg::OP_UPDATE, 998, FRAC_HALF - 16'd1, 16'(pplu_pkg::ALPHA_RST16),
                0, 0, 0);
        wait_drained();

        run_phase(16'(pplu_pkg::ALPHA_RST16), 16'(pplu_pkg::BETA_RST16),
                  16'(pplu_pkg::GAMMA_RST16), 16'd8, 8, 140);
        run_phase(16'h0000, 16'h0000, 16'h0000, 16'd2, 8, 140);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF803, 8, 140);
        run_phase(FRAC_HALF, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'd0, 46, 140);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'd2047, 46, 160);
        run_phase(16'($urandom_range(0, 65535)), 16'd1, 16'hFFFE, 16'd1024, 46, 140);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'd16, 0, 140);
        run_phase(16'd20000, 16'd40000, 16'd30000, 16'd1, 0, 140);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'd5, 0, 140);

        repeat (10) @(posedge i_clk);
        if (errors == 0 && count_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(3_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
